// ----- src/tlpik_pkg.sv -----
// Shared types and constants for the two-link planar inverse kinematics core.
package tlpik_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int LEN_W         = 15;
  localparam int RSQ_W         = 2 * COORD_WIDTH;
  localparam int DEN_W         = 31;
  localparam int DIV_N         = 31;
  localparam int SQ_N          = 31;
  localparam int SQ_RW         = 34;
  localparam int SQ_VW         = 62;
  localparam int CW            = 51;
  localparam int ZW            = 34;
  localparam int SCALE_SH      = 46 - COORD_WIDTH;
  localparam int Q_FRAC        = 30;
  localparam int CORD_LAT      = CORDIC_STAGES + 1;
  localparam int NB            = DIV_N + SQ_N + 6 + CORD_LAT;
  localparam int S_IDX         = DIV_N + SQ_N + 4;
  localparam int K_IDX         = NB - CORD_LAT - 1;
  localparam int QDEPTH        = 4;
  localparam int QAW           = 2;
  localparam int BASE_W        = 16;
  localparam int ELBOW_W       = 15;
  localparam int RSH           = 18;

  localparam logic [LEN_W-1:0] UPPER_RST = 15'd2048;
  localparam logic [LEN_W-1:0] LOWER_RST = 15'd1638;

  localparam logic signed [ZW-1:0] DEG90 = 34'sd1509949440;
  localparam logic signed [ZW:0] RND       = 35'sd131072;
  localparam logic signed [ZW:0] BASE_LIM  = 35'sd23040;
  localparam logic signed [ZW:0] ELBOW_LIM = 35'sd11520;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717, 32'd15018523, 32'd7509720, 32'd3754917, 32'd1877466,
    32'd938734, 32'd469367, 32'd234684, 32'd117342, 32'd58671, 32'd29335,
    32'd14668, 32'd7334, 32'd3667, 32'd1833, 32'd917, 32'd458, 32'd229,
    32'd115, 32'd57, 32'd29, 32'd14, 32'd7, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef enum logic [0:0] {
    CFG_UPPER = 1'b0,
    CFG_LOWER = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          up;
    logic                          reach;
    logic                          dz;
  } tlpik_side_t;

  typedef struct packed {
    tlpik_side_t      side;
    logic [DEN_W-1:0] mag;
    logic             neg;
    logic [DEN_W-1:0] den;
  } tlpik_req_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] q;
    logic [DEN_W-1:0] nb;
    logic [DEN_W-1:0] den;
    logic             neg;
  } tlpik_div_t;

  typedef struct packed {
    logic [SQ_RW-1:0]   rem;
    logic [DEN_W-1:0]   root;
    logic [SQ_VW-1:0]   v;
    logic signed [31:0] c;
  } tlpik_sq_t;

endpackage

// ----- src/two_link_planar_inverse_kinematics_core.sv -----
// Top level: two-link planar arm inverse kinematics core.
// Throughput: one request per cycle while the output is not stalled; the divider, square root
// and CORDIC chains are fully pipelined.
// A four-entry queue decouples the front end from the solver; output stalls freeze the solver.
// Reset (rst_ni low, async): pipelines and queue empty, link lengths 2048 and 1638.
module two_link_planar_inverse_kinematics_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // target_x_pos[15:0], target_y_pos[31:16]
  input  logic        s_axis_tuser,   // elbow_up_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // base_angle[15:0], elbow_angle[30:16], zero[31]
  output logic        m_axis_tuser,   // reachable_flag
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  logic [tlpik_pkg::LEN_W-1:0] l1_q, l2_q;
  logic req_valid, q_ready, q_valid, q_pop;
  tlpik_pkg::tlpik_req_t req, q_head;
  logic signed [tlpik_pkg::BASE_W-1:0]  base;
  logic signed [tlpik_pkg::ELBOW_W-1:0] elbow;
  logic reach;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= tlpik_pkg::UPPER_RST;
      l2_q <= tlpik_pkg::LOWER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlpik_pkg::CFG_UPPER: l1_q <= cfg_data_i;
        tlpik_pkg::CFG_LOWER: l2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tlpik_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .x_i         (s_axis_tdata[15:0]),
    .y_i         (s_axis_tdata[31:16]),
    .up_i        (s_axis_tuser),
    .l1_i        (l1_q),
    .l2_i        (l2_q),
    .req_valid_o (req_valid),
    .req_ready_i (q_ready),
    .req_o       (req)
  );

  tlpik_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_valid),
    .ready_o (q_ready),
    .data_i  (req),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_head)
  );

  tlpik_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_pop_o   (q_pop),
    .req_i       (q_head),
    .l1_i        (l1_q),
    .l2_i        (l2_q),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .base_o      (base),
    .elbow_o     (elbow),
    .reach_o     (reach)
  );

  assign m_axis_tdata = {1'b0, elbow, base};
  assign m_axis_tuser = reach;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("unreachable target with nonzero angles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd11520 &&
                       $signed(m_axis_tdata[30:16]) >= -15'sd11520))
    else $error("elbow angle out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd23040 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd23040))
    else $error("base angle out of range");

endmodule

// ----- src/tlpik_front.sv -----
// Front end: accepts requests, squares terms, checks reachability, forms the cosine numerator.
module tlpik_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic signed [tlpik_pkg::COORD_WIDTH-1:0]  x_i,
  input  logic signed [tlpik_pkg::COORD_WIDTH-1:0]  y_i,
  input  logic                                      up_i,
  input  logic [tlpik_pkg::LEN_W-1:0]               l1_i,
  input  logic [tlpik_pkg::LEN_W-1:0]               l2_i,
  output logic                                      req_valid_o,
  input  logic                                      req_ready_i,
  output tlpik_pkg::tlpik_req_t                     req_o
);

  logic adv;
  logic f1_vld_q, f2_vld_q;
  logic signed [tlpik_pkg::COORD_WIDTH-1:0] x1_q, y1_q;
  logic up1_q;
  logic [tlpik_pkg::RSQ_W-1:0] ax2_q, ay2_q, l1sq_q, l2sq_q, sumsq_q, difsq_q;
  logic [tlpik_pkg::DEN_W-1:0] den_q;
  logic [tlpik_pkg::COORD_WIDTH-1:0] ax, ay;
  logic [tlpik_pkg::LEN_W:0] sum;
  logic [tlpik_pkg::LEN_W-1:0] dif;
  logic [tlpik_pkg::RSQ_W-1:0] rsq;
  logic signed [tlpik_pkg::RSQ_W+1:0] num, magw;
  tlpik_pkg::tlpik_req_t req_d, req_q;

  assign adv         = !f2_vld_q || req_ready_i;
  assign ready_o     = adv;
  assign req_valid_o = f2_vld_q;
  assign req_o       = req_q;

  always_comb begin
    ax  = x_i[tlpik_pkg::COORD_WIDTH-1] ? tlpik_pkg::COORD_WIDTH'(-x_i)
                                        : tlpik_pkg::COORD_WIDTH'(x_i);
    ay  = y_i[tlpik_pkg::COORD_WIDTH-1] ? tlpik_pkg::COORD_WIDTH'(-y_i)
                                        : tlpik_pkg::COORD_WIDTH'(y_i);
    sum = {1'b0, l1_i} + {1'b0, l2_i};
    dif = (l1_i > l2_i) ? l1_i - l2_i : l2_i - l1_i;
  end

  always_comb begin
    rsq  = ax2_q + ay2_q;
    num  = $signed({2'b00, rsq}) - $signed({2'b00, l1sq_q}) - $signed({2'b00, l2sq_q});
    magw = num[tlpik_pkg::RSQ_W+1] ? -num : num;
    req_d.side.x     = x1_q;
    req_d.side.y     = y1_q;
    req_d.side.up    = up1_q;
    req_d.side.reach = !((rsq > sumsq_q) || (rsq < difsq_q));
    req_d.side.dz    = (den_q == '0);
    req_d.mag        = magw[tlpik_pkg::DEN_W-1:0];
    req_d.neg        = num[tlpik_pkg::RSQ_W+1];
    req_d.den        = den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q <= valid_i;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_q    <= x_i;
      y1_q    <= y_i;
      up1_q   <= up_i;
      ax2_q   <= tlpik_pkg::RSQ_W'(ax) * tlpik_pkg::RSQ_W'(ax);
      ay2_q   <= tlpik_pkg::RSQ_W'(ay) * tlpik_pkg::RSQ_W'(ay);
      l1sq_q  <= tlpik_pkg::RSQ_W'(l1_i) * tlpik_pkg::RSQ_W'(l1_i);
      l2sq_q  <= tlpik_pkg::RSQ_W'(l2_i) * tlpik_pkg::RSQ_W'(l2_i);
      sumsq_q <= tlpik_pkg::RSQ_W'(sum) * tlpik_pkg::RSQ_W'(sum);
      difsq_q <= tlpik_pkg::RSQ_W'(dif) * tlpik_pkg::RSQ_W'(dif);
      den_q   <= (tlpik_pkg::DEN_W'(l1_i) * tlpik_pkg::DEN_W'(l2_i)) << 1;
      req_q   <= req_d;
    end
  end

endmodule

// ----- src/tlpik_queue.sv -----
// Short request queue between the front end and the solver pipeline.
module tlpik_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  ready_o,
  input  tlpik_pkg::tlpik_req_t data_i,
  output logic                  valid_o,
  input  logic                  pop_i,
  output tlpik_pkg::tlpik_req_t data_o
);

  tlpik_pkg::tlpik_req_t mem_q [tlpik_pkg::QDEPTH];
  logic [tlpik_pkg::QAW-1:0] wr_q, rd_q;
  logic [tlpik_pkg::QAW:0]   cnt_q;
  logic do_push, do_pop;

  assign ready_o = (cnt_q != (tlpik_pkg::QAW+1)'(tlpik_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (tlpik_pkg::QAW+1)'(do_push) - (tlpik_pkg::QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (tlpik_pkg::QAW+1)'(tlpik_pkg::QDEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !do_pop)
    else $error("pop from empty queue");

endmodule

// ----- src/tlpik_cordic.sv -----
// Pipelined vectoring CORDIC: atan2 in degrees Q24 with quadrant pre-rotation.
module tlpik_cordic (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [tlpik_pkg::CW-1:0] x_i,
  input  logic signed [tlpik_pkg::CW-1:0] y_i,
  output logic signed [tlpik_pkg::ZW-1:0] z_o
);

  localparam int N = tlpik_pkg::CORDIC_STAGES;

  logic signed [tlpik_pkg::CW-1:0] x_q [N+1];
  logic signed [tlpik_pkg::CW-1:0] y_q [N+1];
  logic signed [tlpik_pkg::ZW-1:0] z_q [N+1];
  logic                            zf_q [N+1];

  assign z_o = zf_q[N] ? '0 : z_q[N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zf_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          z_q[0] <= tlpik_pkg::DEG90;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          z_q[0] <= -tlpik_pkg::DEG90;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
      for (int k = 0; k < N; k++) begin
        zf_q[k+1] <= zf_q[k];
        if (y_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + $signed(tlpik_pkg::ZW'(tlpik_pkg::ATAN_TAB[k]));
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - $signed(tlpik_pkg::ZW'(tlpik_pkg::ATAN_TAB[k]));
        end
      end
    end
  end

endmodule

// ----- src/tlpik_back.sv -----
// Solver pipeline: cosine divider, sine square root, three CORDICs, rounding and output register.
module tlpik_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  output logic                                 req_pop_o,
  input  tlpik_pkg::tlpik_req_t                req_i,
  input  logic [tlpik_pkg::LEN_W-1:0]          l1_i,
  input  logic [tlpik_pkg::LEN_W-1:0]          l2_i,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic signed [tlpik_pkg::BASE_W-1:0]  base_o,
  output logic signed [tlpik_pkg::ELBOW_W-1:0] elbow_o,
  output logic                                 reach_o
);

  function automatic tlpik_pkg::tlpik_div_t div_step(input tlpik_pkg::tlpik_div_t a);
    tlpik_pkg::tlpik_div_t r;
    logic [tlpik_pkg::DEN_W:0] t;
    r    = a;
    t    = {a.rem, a.nb[tlpik_pkg::DEN_W-1]};
    r.nb = {a.nb[tlpik_pkg::DEN_W-2:0], 1'b0};
    if (t >= {1'b0, a.den}) begin
      r.rem = tlpik_pkg::DEN_W'(t - {1'b0, a.den});
      r.q   = {a.q[tlpik_pkg::DEN_W-2:0], 1'b1};
    end else begin
      r.rem = t[tlpik_pkg::DEN_W-1:0];
      r.q   = {a.q[tlpik_pkg::DEN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic tlpik_pkg::tlpik_sq_t sq_step(input tlpik_pkg::tlpik_sq_t a);
    tlpik_pkg::tlpik_sq_t r;
    logic [tlpik_pkg::SQ_RW+1:0] t, trial;
    r     = a;
    t     = {a.rem, a.v[tlpik_pkg::SQ_VW-1:tlpik_pkg::SQ_VW-2]};
    trial = {3'b000, a.root, 2'b01};
    r.v   = a.v << 2;
    if (t >= trial) begin
      r.rem  = tlpik_pkg::SQ_RW'(t - trial);
      r.root = {a.root[tlpik_pkg::DEN_W-2:0], 1'b1};
    end else begin
      r.rem  = t[tlpik_pkg::SQ_RW-1:0];
      r.root = {a.root[tlpik_pkg::DEN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  localparam logic [tlpik_pkg::DEN_W-1:0] Q30_U = 31'h4000_0000;
  localparam logic signed [31:0]          Q30_S = 32'sh4000_0000;

  logic en;
  logic                  vld_q  [tlpik_pkg::NB];
  tlpik_pkg::tlpik_side_t side_q [tlpik_pkg::NB];
  tlpik_pkg::tlpik_div_t  div_q  [tlpik_pkg::DIV_N+1];
  tlpik_pkg::tlpik_div_t  div0;
  tlpik_pkg::tlpik_sq_t   sq_q   [tlpik_pkg::SQ_N+1];
  tlpik_pkg::tlpik_sq_t   sq0;
  logic [tlpik_pkg::DEN_W-1:0] qc;
  logic signed [31:0] c_d, c_q, csc_q, s_d, s_q, sc_q;
  logic [31:0] cm;
  logic [tlpik_pkg::SQ_VW-1:0] csq_q;
  logic signed [tlpik_pkg::LEN_W:0] l2s;
  logic signed [47:0] p1, p2;
  logic signed [tlpik_pkg::CW-1:0] kx_q, ky_q, ts_q, tc_q, ax_in, ay_in;
  logic signed [tlpik_pkg::ZW-1:0] zt, za, zb;
  logic signed [tlpik_pkg::ZW:0] th1, th2, r1, r2;
  logic signed [tlpik_pkg::BASE_W-1:0]  base_d, base_q;
  logic signed [tlpik_pkg::ELBOW_W-1:0] elbow_d, elbow_q;
  logic reach_d, reach_q, o_vld_q;
  tlpik_pkg::tlpik_side_t side_k, side_o;

  assign en        = !o_vld_q || m_ready_i;
  assign req_pop_o = en;
  assign m_valid_o = o_vld_q;
  assign base_o    = base_q;
  assign elbow_o   = elbow_q;
  assign reach_o   = reach_q;
  assign side_k    = side_q[tlpik_pkg::K_IDX];
  assign side_o    = side_q[tlpik_pkg::NB-1];

  always_comb begin
    div0.rem = {1'b0, req_i.mag[tlpik_pkg::DEN_W-1:1]};
    div0.q   = '0;
    div0.nb  = {req_i.mag[0], req_i.den[tlpik_pkg::DEN_W-1:1]};
    div0.den = req_i.den;
    div0.neg = req_i.neg;

    qc  = (div_q[tlpik_pkg::DIV_N].q > Q30_U) ? Q30_U : div_q[tlpik_pkg::DIV_N].q;
    if (side_q[tlpik_pkg::DIV_N].dz) begin
      c_d = Q30_S;
    end else if (div_q[tlpik_pkg::DIV_N].neg) begin
      c_d = -$signed({1'b0, qc});
    end else begin
      c_d = $signed({1'b0, qc});
    end

    cm = c_q[31] ? 32'(-c_q) : 32'(c_q);

    sq0.rem  = '0;
    sq0.root = '0;
    sq0.v    = (tlpik_pkg::SQ_VW'(1) << 60) - csq_q;
    sq0.c    = csc_q;

    s_d = side_q[tlpik_pkg::S_IDX-1].up ? -$signed({1'b0, sq_q[tlpik_pkg::SQ_N].root})
                                        : $signed({1'b0, sq_q[tlpik_pkg::SQ_N].root});

    l2s = $signed({1'b0, l2_i});
    p1  = l2s * sc_q;
    p2  = l2s * s_q;

    ax_in = tlpik_pkg::CW'(side_k.x) <<< tlpik_pkg::SCALE_SH;
    ay_in = tlpik_pkg::CW'(side_k.y) <<< tlpik_pkg::SCALE_SH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < tlpik_pkg::NB; j++) vld_q[j] <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= req_valid_i;
      for (int j = 1; j < tlpik_pkg::NB; j++) vld_q[j] <= vld_q[j-1];
      o_vld_q <= vld_q[tlpik_pkg::NB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= req_i.side;
      for (int j = 1; j < tlpik_pkg::NB; j++) side_q[j] <= side_q[j-1];
      div_q[0] <= div0;
      for (int k = 0; k < tlpik_pkg::DIV_N; k++) div_q[k+1] <= div_step(div_q[k]);
      c_q   <= c_d;
      csq_q <= tlpik_pkg::SQ_VW'(cm[30:0]) * tlpik_pkg::SQ_VW'(cm[30:0]);
      csc_q <= c_q;
      sq_q[0] <= sq0;
      for (int k = 0; k < tlpik_pkg::SQ_N; k++) sq_q[k+1] <= sq_step(sq_q[k]);
      s_q  <= s_d;
      sc_q <= sq_q[tlpik_pkg::SQ_N].c;
      kx_q <= (tlpik_pkg::CW'($signed({1'b0, l1_i})) <<< tlpik_pkg::Q_FRAC)
              + tlpik_pkg::CW'(p1);
      ky_q <= tlpik_pkg::CW'(p2);
      ts_q <= tlpik_pkg::CW'(s_q);
      tc_q <= tlpik_pkg::CW'(sc_q);
      base_q  <= base_d;
      elbow_q <= elbow_d;
      reach_q <= reach_d;
    end
  end

  tlpik_cordic u_cord_t (.clk_i(clk_i), .en_i(en), .x_i(tc_q),  .y_i(ts_q),  .z_o(zt));
  tlpik_cordic u_cord_a (.clk_i(clk_i), .en_i(en), .x_i(ax_in), .y_i(ay_in), .z_o(za));
  tlpik_cordic u_cord_b (.clk_i(clk_i), .en_i(en), .x_i(kx_q),  .y_i(ky_q),  .z_o(zb));

  always_comb begin
    th1 = $signed({za[tlpik_pkg::ZW-1], za}) - $signed({zb[tlpik_pkg::ZW-1], zb});
    th2 = $signed({zt[tlpik_pkg::ZW-1], zt});
    r1  = (th1 + tlpik_pkg::RND) >>> tlpik_pkg::RSH;
    r2  = (th2 + tlpik_pkg::RND) >>> tlpik_pkg::RSH;
    if (r1 > tlpik_pkg::BASE_LIM) r1 = tlpik_pkg::BASE_LIM;
    if (r1 < -tlpik_pkg::BASE_LIM) r1 = -tlpik_pkg::BASE_LIM;
    if (r2 > tlpik_pkg::ELBOW_LIM) r2 = tlpik_pkg::ELBOW_LIM;
    if (r2 < -tlpik_pkg::ELBOW_LIM) r2 = -tlpik_pkg::ELBOW_LIM;
    reach_d = side_o.reach;
    base_d  = side_o.reach ? r1[tlpik_pkg::BASE_W-1:0] : '0;
    elbow_d = side_o.reach ? r2[tlpik_pkg::ELBOW_W-1:0] : '0;
  end

endmodule

// ----- verif/two_link_planar_inverse_kinematics_core_tb.sv -----
// Testbench for the two-link planar inverse kinematics core: predicted angles vs. DUT stream.
`timescale 1ns / 1ps

module two_link_planar_inverse_kinematics_core_tb;

  typedef struct packed {
    logic signed [15:0] base;
    logic signed [14:0] elbow;
    logic               reach;
  } ik_sol_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = tlpik_pkg::CFG_UPPER;
  logic [14:0] cfg_data_i = '0;

  two_link_planar_inverse_kinematics_core i_dut (.*);

  always #5 clk_i = ~clk_i;

  longint unsigned upper_len = tlpik_pkg::UPPER_RST;
  longint unsigned lower_len = tlpik_pkg::LOWER_RST;
  ik_sol_t sol_q[$];
  int errors = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_cycles = 0;
  longint cycle_cnt = 0;

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint atan2_deg(longint yy, longint xx);
    longint z = 0;
    longint t, nx, ny;
    if (xx == 0 && yy == 0) return 0;
    if (xx < 0) begin
      if (yy >= 0) begin
        t = xx; xx = yy; yy = -t; z = 64'sd1509949440;
      end else begin
        t = xx; xx = -yy; yy = t; z = -64'sd1509949440;
      end
    end
    for (int i = 0; i < tlpik_pkg::CORDIC_STAGES && i < 32; i++) begin
      if (yy >= 0) begin
        nx = xx + sra(yy, i); ny = yy - sra(xx, i);
        z += longint'(tlpik_pkg::ATAN_TAB[i]);
      end else begin
        nx = xx - sra(yy, i); ny = yy + sra(xx, i);
        z -= longint'(tlpik_pkg::ATAN_TAB[i]);
      end
      xx = nx; yy = ny;
    end
    return z;
  endfunction

  function automatic longint deg_q6(longint z, longint lim);
    longint r = sra(z + (64'sd1 << 17), 18);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic ik_sol_t solve_ik(logic signed [15:0] tx, logic signed [15:0] ty,
                                       logic up);
    ik_sol_t o;
    longint x = tx;
    longint y = ty;
    longint unsigned ax = (x < 0) ? -x : x;
    longint unsigned ay = (y < 0) ? -y : y;
    longint unsigned rsq = ax * ax + ay * ay;
    longint unsigned sum = upper_len + lower_len;
    longint unsigned dif = (upper_len > lower_len) ? upper_len - lower_len
                                                   : lower_len - upper_len;
    longint unsigned den = 2 * upper_len * lower_len;
    longint unsigned mag, q;
    longint num, c, s, th1, th2;
    o = '0;
    if (rsq > sum * sum || rsq < dif * dif) return o;
    if (den == 0) begin
      c = 64'sd1 << 30;
    end else begin
      num = longint'(rsq) - longint'(upper_len * upper_len) - longint'(lower_len * lower_len);
      mag = (num < 0) ? -num : num;
      q = ((mag << 30) + den / 2) / den;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      c = (num < 0) ? -longint'(q) : longint'(q);
    end
    s = longint'(int_sqrt((64'd1 << 60) - longint'(c * c)));
    if (up) s = -s;
    th2 = atan2_deg(s, c);
    th1 = atan2_deg(y * (64'sd1 << tlpik_pkg::SCALE_SH), x * (64'sd1 << tlpik_pkg::SCALE_SH))
        - atan2_deg(longint'(lower_len) * s, longint'(upper_len) * (64'sd1 << 30)
                    + longint'(lower_len) * c);
    o.base  = 16'(deg_q6(th1, 23040));
    o.elbow = 15'(deg_q6(th2, 11520));
    o.reach = 1'b1;
    return o;
  endfunction

  task automatic send_point(logic signed [15:0] tx, logic signed [15:0] ty, logic up);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ty, tx};
    s_axis_tuser  <= up;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sol_q.push_back(solve_ik(tx, ty, up));
  endtask

  task automatic write_len(tlpik_pkg::cfg_idx_e idx, logic [14:0] v);
    s_axis_tvalid <= 1'b0;
    while (sol_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tlpik_pkg::CFG_UPPER) upper_len = v;
    else lower_len = v;
  endtask

  // Point at random radius in the workspace annulus, random angle.
  task automatic send_reachable();
    real rmin, rmax, r, a;
    longint sx, sy;
    rmin = (upper_len > lower_len) ? upper_len - lower_len : lower_len - upper_len;
    rmax = upper_len + lower_len;
    r = rmin + (rmax - rmin) * $urandom_range(1000) / 1000.0;
    a = 6.283185307 * $urandom_range(1 << 20) / 1048576.0;
    sx = longint'(r * $cos(a));
    sy = longint'(r * $sin(a));
    if (sx > 32767) sx = 32767;
    if (sx < -32768) sx = -32768;
    if (sy > 32767) sy = 32767;
    if (sy < -32768) sy = -32768;
    send_point(16'(sx), 16'(sy), 1'($urandom));
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) send_reachable();
      else send_point(16'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  task automatic test_directed();
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd3686, 16'sd0, 1'b0);
    send_point(16'sd3686, 16'sd0, 1'b1);
    send_point(16'sd410, 16'sd0, 1'b0);
    send_point(-16'sd410, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd2500, 1'b0);
    send_point(16'sd0, -16'sd2500, 1'b1);
    send_point(-16'sd2000, 16'sd1500, 1'b1);
    send_point(-16'sd2000, -16'sd1500, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(-16'sd32768, -16'sd32768, 1'b1);
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(16'sd3687, 16'sd0, 1'b0);
    send_point(-16'sd32768, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd32767, 1'b1);
  endtask

  task automatic test_config_sweep();
    write_len(tlpik_pkg::CFG_UPPER, 15'd1);
    write_len(tlpik_pkg::CFG_LOWER, 15'd1);
    send_point(16'sd2, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sd1, 16'sd1, 1'b1);
    send_random(20);
    write_len(tlpik_pkg::CFG_UPPER, 15'd32767);
    write_len(tlpik_pkg::CFG_LOWER, 15'd32767);
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd0, 1'b1);
    send_random(30);
    write_len(tlpik_pkg::CFG_UPPER, 15'd0);
    send_point(16'sd20000, -16'sd20000, 1'b1);
    send_random(20);
    write_len(tlpik_pkg::CFG_UPPER, 15'd3000);
    write_len(tlpik_pkg::CFG_LOWER, 15'd5000);
    send_random(40);
    write_len(tlpik_pkg::CFG_UPPER, tlpik_pkg::UPPER_RST);
    write_len(tlpik_pkg::CFG_LOWER, tlpik_pkg::LOWER_RST);
  endtask

  // More requests than the pipeline and queue hold, so the input stalls.
  task automatic test_backpressure();
    src_idle_pct = 0;
    hold_cycles = 300;
    send_random(130);
  endtask

  task automatic test_random_traffic();
    src_idle_pct = 28; snk_idle_pct = 60;
    send_random(65);
    src_idle_pct = 60; snk_idle_pct = 28;
    send_random(65);
    src_idle_pct = 0; snk_idle_pct = 0;
    send_random(60);
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    ik_sol_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[30:16], m_axis_tuser};
      if (sol_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = sol_q.pop_front();
        if (got.base !== want.base || got.elbow !== want.elbow
            || got.reach !== want.reach || m_axis_tdata[31] !== 1'b0) begin
          $display("%0t: mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
                   $time, want.base, want.elbow, want.reach, got.base, got.elbow, got.reach);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (sol_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
